/* hw/rtl/dipc_pkg.sv */
// ----------------------------------------------------------------------------
// dipc_pkg: shared types, constants and sine ROM for the point cloud core
// Holds register indexes, fixed-point limits, command/status structs and the
// quarter-wave sine table.
// ----------------------------------------------------------------------------
package dipc_pkg;

  localparam int MAX_RES          = 1024;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int CNT_W            = $clog2(MAX_RES);
  localparam int RES_W            = 11;
  localparam int DEPTH_W          = 21;

  localparam logic [2:0] REG_RES_COLS    = 3'd0;
  localparam logic [2:0] REG_RES_ROWS    = 3'd1;
  localparam logic [2:0] REG_RANGE_MIN   = 3'd2;
  localparam logic [2:0] REG_RANGE_MAX   = 3'd3;
  localparam logic [2:0] REG_NEAR_MARGIN = 3'd4;
  localparam logic [2:0] REG_FOV         = 3'd5;
  localparam logic [2:0] REG_SCALE       = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int DIV_NUM_W = 29;
  localparam int DIV_DEN_W = 12;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // sine index = round(|angle| * 1024 / 102944); 102944 = 32 * 3217
  localparam logic [DIV_NUM_W-1:0] IDX_SAT_MAG = 29'd102894;
  localparam logic [21:0]          IDX_ROUND   = 22'd1608;
  localparam logic [22:0]          IDX_RECIP   = 23'd5340339;
  localparam int                   IDX_SHIFT   = 34;
  localparam longint               HALF_PI_Q30 = 64'd1686629713;

  localparam logic [22:0] LAT_MAG_MAX = 23'd2097152;
  localparam logic [21:0] LAT_MAX     = 22'd2097151;
  localparam logic [20:0] DEPTH_MAX   = 21'd1048575;

  // divider job selector
  localparam logic PH_COL_ANG = 1'b0;
  localparam logic PH_ROW_ANG = 1'b1;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       div_start;
    logic       div_capture;
    logic       rom;
    logic       lat;
    logic       out_load;
    logic       phase;
  } dipc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dipc_status_t;

  typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic logic [15:0] sine_entry(int i);
    logic [63:0] th;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    th   = (64'(i) * 64'(HALF_PI_Q30)) / 64'(SINE_TABLE_DEPTH);
    term = th;
    sum  = longint'(th);
    for (int k = 1; k <= 10; k++) begin
      term = (term * th) >> 30;
      term = (term * th) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (64'(sum) + 64'd8192) >> 14;
    if (v > 64'd65535) v = 64'd65535;
    return v[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) r[i] = sine_entry(i);
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* hw/rtl/dipc_if.sv */
// ----------------------------------------------------------------------------
// dipc_if: valid/ready channel interfaces for pixels, points and config
// Each interface carries valid, ready and its payload.
// ----------------------------------------------------------------------------
interface dipc_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_sample;
  logic        frame_start;
  modport source (output valid, depth_sample, frame_start, input ready);
  modport sink (input valid, depth_sample, frame_start, output ready);
endinterface

interface dipc_point_if;
  logic               valid;
  logic               ready;
  logic signed [21:0] point_x;
  logic signed [21:0] point_y;
  logic [19:0]        point_z;
  logic               keep;
  logic               frame_last;
  modport source (output valid, point_x, point_y, point_z, keep, frame_last, input ready);
  modport sink (input valid, point_x, point_y, point_z, keep, frame_last, output ready);
endinterface

interface dipc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/dipc_div.sv */
// ----------------------------------------------------------------------------
// dipc_div: restoring unsigned divider
// One quotient bit per cycle; done stays high until the next start.
// ----------------------------------------------------------------------------
module dipc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dipc_pkg::DIV_NUM_W-1:0] num,
  input  logic [dipc_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [dipc_pkg::DIV_NUM_W-1:0] quot
);
  import dipc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_NUM_W-1:0] shreg;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dreg;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, shreg[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, dreg};
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= DIV_CNT_W'(DIV_NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      rem   <= '0;
      dreg  <= den;
    end else if (busy) begin
      rem   <= fits ? DIV_DEN_W'(trial - {1'b0, dreg}) : trial[DIV_DEN_W-1:0];
      shreg <= {shreg[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

/* hw/rtl/dipc_ctrl.sv */
// ----------------------------------------------------------------------------
// dipc_ctrl: sequencer for one pixel at a time
// Steps the datapath through depth, two angle divisions, sine lookup and output.
// ----------------------------------------------------------------------------
module dipc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  dipc_pkg::dipc_status_t  status,
  output dipc_pkg::dipc_cmd_t     cmd
);
  import dipc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_ROM    = 3'd4;
  localparam logic [2:0] S_LAT    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state, state_next;
  logic       phase, phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.phase  = phase;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        phase_next = PH_COL_ANG;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          cmd.div_capture = 1'b1;
          if (phase == PH_ROW_ANG) begin
            state_next = S_ROM;
          end else begin
            phase_next = PH_ROW_ANG;
            state_next = S_DSTART;
          end
        end
      end
      S_ROM: begin
        cmd.rom    = 1'b1;
        state_next = S_LAT;
      end
      S_LAT: begin
        cmd.lat    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_COL_ANG;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

/* hw/rtl/dipc_datapath.sv */
// ----------------------------------------------------------------------------
// dipc_datapath: registers, counters and arithmetic of the projection
// Holds configuration, pixel counters, shared divider, sine ROM and the
// output register.
// ----------------------------------------------------------------------------
module dipc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dipc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dipc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [15:0]                   depth_sample,
  input  logic                          frame_start,
  input  dipc_pkg::dipc_cmd_t           cmd,
  output dipc_pkg::dipc_status_t        status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [21:0]            point_x,
  output logic signed [21:0]            point_y,
  output logic [19:0]                   point_z,
  output logic                          keep,
  output logic                          frame_last
);
  import dipc_pkg::*;

  logic [RES_W-1:0] res_cols, res_rows;
  logic [19:0]      range_min, range_max;
  logic [15:0]      near_margin;
  logic [17:0]      fov, scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cols    <= 11'd256;
      res_rows    <= 11'd256;
      range_min   <= 20'd655;
      range_max   <= 20'd229376;
      near_margin <= 16'd655;
      fov         <= 18'd65198;
      scale       <= 18'd73843;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RES_COLS:    res_cols    <= cfg_data[RES_W-1:0];
        REG_RES_ROWS:    res_rows    <= cfg_data[RES_W-1:0];
        REG_RANGE_MIN:   range_min   <= cfg_data;
        REG_RANGE_MAX:   range_max   <= cfg_data;
        REG_NEAR_MARGIN: near_margin <= cfg_data[15:0];
        REG_FOV:         fov         <= cfg_data[17:0];
        REG_SCALE:       scale       <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  function automatic logic [RES_W-1:0] eff_res(logic [RES_W-1:0] r);
    if (r == '0) return RES_W'(1);
    if (r > RES_W'(MAX_RES)) return RES_W'(MAX_RES);
    return r;
  endfunction

  logic [RES_W-1:0] cols, rows;
  assign cols = eff_res(res_cols);
  assign rows = eff_res(res_rows);

  // pixel counters
  logic [CNT_W-1:0] column_count, row_count;
  logic [CNT_W-1:0] cc, rc;
  logic [CNT_W-1:0] cc_cur, rc_cur;
  logic             last;

  assign cc_cur = frame_start ? '0 : column_count;
  assign rc_cur = frame_start ? '0 : row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.load) begin
      if ({1'b0, rc_cur} + 1'b1 >= rows) begin
        row_count <= '0;
        if ({1'b0, cc_cur} + 1'b1 >= cols) column_count <= '0;
        else column_count <= cc_cur + 1'b1;
      end else begin
        row_count    <= rc_cur + 1'b1;
        column_count <= cc_cur;
      end
    end
  end

  logic [DEPTH_W-1:0] depth;
  logic [35:0]        samp_prod;
  assign samp_prod = depth_sample * range_max;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cc    <= cc_cur;
      rc    <= rc_cur;
      last  <= ({1'b0, rc_cur} + 1'b1 >= rows) && ({1'b0, cc_cur} + 1'b1 >= cols);
      depth <= DEPTH_W'(range_min) + DEPTH_W'(samp_prod[35:16]);
    end
  end

  // keep test, depth*scale and angle numerators
  logic signed [12:0] num_c, num_r;
  logic        [11:0] mag_nc, mag_nr;
  logic        [29:0] prod_c, prod_r;
  logic signed [21:0] thresh;
  logic        [38:0] ds;
  logic [DIV_NUM_W-1:0] anum_c, anum_r;
  logic               neg_c, neg_r, keep_r;

  assign num_c  = $signed({2'b0, cc, 1'b0}) - $signed({2'b0, cols});
  assign num_r  = $signed({2'b0, rc, 1'b0}) - $signed({2'b0, rows});
  assign mag_nc = num_c[12] ? 12'(-num_c) : num_c[11:0];
  assign mag_nr = num_r[12] ? 12'(-num_r) : num_r[11:0];
  assign prod_c = mag_nc * fov;
  assign prod_r = mag_nr * fov;
  assign thresh = $signed({2'b0, range_max}) - $signed({6'b0, near_margin});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      anum_c <= prod_c[DIV_NUM_W-1:0];
      anum_r <= prod_r[DIV_NUM_W-1:0];
      neg_c  <= num_c[12];
      // row angle is negated
      neg_r  <= !num_r[12];
      keep_r <= $signed({1'b0, depth}) < thresh;
      ds     <= depth * scale;
    end
  end

  // shared divider for the two angles
  logic [IDX_W-1:0]     idx_c, idx_r;
  logic [IDX_W-1:0]     idx_q;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] quot;
  logic                 div_done;

  // round(|angle| * 1024 / 102944): scale by 32 exactly, then divide by 3217
  // through a reciprocal that is exact over the whole unsaturated range
  function automatic logic [IDX_W-1:0] sine_index(logic [DIV_NUM_W-1:0] a);
    logic [21:0] scaled;
    logic [44:0] prod;
    if (a >= IDX_SAT_MAG) return '1;
    scaled = {a[16:0], 5'b0} + IDX_ROUND;
    prod   = scaled * IDX_RECIP;
    return prod[IDX_SHIFT+IDX_W-1:IDX_SHIFT];
  endfunction

  assign idx_q = sine_index(quot);

  always_comb begin
    case (cmd.phase)
      PH_COL_ANG: begin
        div_num = anum_c;
        div_den = DIV_DEN_W'({cols, 1'b0});
      end
      default: begin
        div_num = anum_r;
        div_den = DIV_DEN_W'({rows, 1'b0});
      end
    endcase
  end

  dipc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      case (cmd.phase)
        PH_COL_ANG: idx_c <= idx_q;
        default:    idx_r <= idx_q;
      endcase
    end
  end

  // sine ROM, registered read
  logic [15:0] sin_c, sin_r;
  always_ff @(posedge clk) begin
    if (cmd.rom) begin
      sin_c <= SINE_ROM[idx_c];
      sin_r <= SINE_ROM[idx_r];
    end
  end

  // lateral magnitudes
  logic [54:0] lat_pc, lat_pr;
  logic [22:0] mag_x, mag_y;
  assign lat_pc = sin_c * ds;
  assign lat_pr = sin_r * ds;

  always_ff @(posedge clk) begin
    if (cmd.lat) begin
      mag_y <= lat_pc[54:32] > LAT_MAG_MAX ? LAT_MAG_MAX : lat_pc[54:32];
      mag_x <= lat_pr[54:32] > LAT_MAG_MAX ? LAT_MAG_MAX : lat_pr[54:32];
    end
  end

  function automatic logic [21:0] apply_sign(logic [22:0] m, logic neg);
    if (neg) return 22'(-m);
    if (m == LAT_MAG_MAX) return LAT_MAX;
    return m[21:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      keep       <= keep_r;
      frame_last <= last;
      point_x    <= keep_r ? $signed(apply_sign(mag_x, neg_r)) : '0;
      point_y    <= keep_r ? $signed(apply_sign(mag_y, neg_c)) : '0;
      point_z    <= keep_r ? ((depth > DEPTH_MAX) ? DEPTH_MAX[19:0] : depth[19:0]) : '0;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

/* hw/rtl/depth_image_to_point_cloud_core.sv */
// ----------------------------------------------------------------------------
// depth_image_to_point_cloud_core: depth pixel to 3D point projection
// Takes one depth pixel per transaction and returns one point per pixel.
// ----------------------------------------------------------------------------
// Each pixel passes through load, multiply, two divider passes (start,
// shift-and-subtract, capture) for the angles, sine lookup, lateral step and output.
// The next pixel is taken while the last point waits in the output register,
// and a full output register holds the core.
// Reset: synchronous; registers return to defaults, counters clear.
module depth_image_to_point_cloud_core (
  input  logic  clk,
  input  logic  rst,
  dipc_pixel_if.sink  pixel,
  dipc_point_if.source point,
  dipc_cfg_if.sink    cfg
);
  import dipc_pkg::*;

  dipc_cmd_t    cmd;
  dipc_status_t status;

  assign cfg.ready = 1'b1;

  dipc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (pixel.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dipc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .depth_sample (pixel.depth_sample),
    .frame_start  (pixel.frame_start),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (point.valid),
    .out_ready    (point.ready),
    .point_x      (point.point_x),
    .point_y      (point.point_y),
    .point_z      (point.point_z),
    .keep         (point.keep),
    .frame_last   (point.frame_last)
  );

endmodule
